>>> src/rsbb_pkg.sv
// shared widths, constants, stage types and the arctangent table of the bounding box unit
package rsbb_pkg;

    localparam int ATAN_ENTRIES = 24;

    localparam int ANG_W  = 19;
    localparam int POS_W  = 32;
    localparam int SCL_W  = 24;
    localparam int OFF_W  = 34;
    localparam int PROD_W = 58;
    localparam int TX_W   = 42;
    localparam int XY_W   = 33;
    localparam int Z_W    = 34;
    localparam int CS_W   = 18;
    localparam int RP_W   = 60;
    localparam int ROT_W  = 45;
    localparam int EDGE_W = 46;

    localparam logic signed [ANG_W-1:0] ANGLE_LIMIT   = 19'sd205887;
    localparam logic signed [ANG_W-1:0] ANGLE_LIMIT_N = -19'sd205887;
    localparam logic signed [Z_W-1:0]   HALF_PI_Q30   = 34'sd1686629713;
    localparam logic signed [Z_W-1:0]   HALF_PI_Q30_N = -34'sd1686629713;
    localparam logic signed [Z_W-1:0]   PI_Q30        = 34'sd3373259426;
    localparam logic signed [XY_W-1:0]  CORDIC_GAIN_Q30 = 33'sd652032874;

    typedef struct packed {
        logic signed [TX_W-1:0]  tx0;
        logic signed [TX_W-1:0]  tx1;
        logic signed [TX_W-1:0]  ty0;
        logic signed [TX_W-1:0]  ty1;
        logic signed [POS_W-1:0] px;
        logic signed [POS_W-1:0] py;
        logic                    zero;
    } t_side;

    typedef struct packed {
        logic signed [XY_W-1:0] x;
        logic signed [XY_W-1:0] y;
        logic signed [Z_W-1:0]  z;
        logic                   neg;
        t_side                  side;
    } t_cstage;

    // atan(2^-i) in Q30, truncated
    function automatic logic [29:0] atan_q30(input logic [4:0] idx);
        logic [29:0] v;
        unique case (idx)
            5'd0:    v = 30'd843314856;
            5'd1:    v = 30'd497837829;
            5'd2:    v = 30'd263043836;
            5'd3:    v = 30'd133525158;
            5'd4:    v = 30'd67021686;
            5'd5:    v = 30'd33543515;
            5'd6:    v = 30'd16775850;
            5'd7:    v = 30'd8388437;
            5'd8:    v = 30'd4194282;
            5'd9:    v = 30'd2097149;
            5'd10:   v = 30'd1048575;
            5'd11:   v = 30'd524287;
            5'd12:   v = 30'd262143;
            5'd13:   v = 30'd131071;
            5'd14:   v = 30'd65535;
            5'd15:   v = 30'd32767;
            5'd16:   v = 30'd16383;
            5'd17:   v = 30'd8191;
            5'd18:   v = 30'd4095;
            5'd19:   v = 30'd2047;
            5'd20:   v = 30'd1023;
            5'd21:   v = 30'd511;
            5'd22:   v = 30'd255;
            5'd23:   v = 30'd127;
            default: v = 30'd0;
        endcase
        return v;
    endfunction

endpackage

>>> src/rotated_sprite_bounding_box.sv
// bounding box of a scaled, rotated sprite: pipelined cordic and corner datapath
//
// channel   direction  handshake                      payload
// command   in         start high, busy low           i_pos_x i_pos_y i_angle i_scale_h i_scale_v
// result    out        o_done strobe, one cycle       o_box_left o_box_top o_box_right o_box_bottom
// config    in         i_cfg_valid and o_cfg_ready    i_cfg_index i_cfg_data
//
// one placement is taken every clock; busy stays low
// o_done follows the input stage, the head stage (angle fold and offset products),
// one cordic iteration per stage, then the trig, multiply, rotate, min/max and
// output stages; the input stage loads on the accepting edge
// synchronous reset clears the valid line and the configuration registers
// results are never held: each one shows for a single cycle
module rotated_sprite_bounding_box #(
    parameter int CORDIC_STEPS = 16
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 start,
    output logic                                 busy,
    input  logic signed [rsbb_pkg::POS_W-1:0]    i_pos_x,
    input  logic signed [rsbb_pkg::POS_W-1:0]    i_pos_y,
    input  logic signed [rsbb_pkg::ANG_W-1:0]    i_angle,
    input  logic signed [rsbb_pkg::SCL_W-1:0]    i_scale_h,
    input  logic signed [rsbb_pkg::SCL_W-1:0]    i_scale_v,
    output logic                                 o_done,
    output logic signed [rsbb_pkg::POS_W-1:0]    o_box_left,
    output logic signed [rsbb_pkg::POS_W-1:0]    o_box_top,
    output logic signed [rsbb_pkg::POS_W-1:0]    o_box_right,
    output logic signed [rsbb_pkg::POS_W-1:0]    o_box_bottom,
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [3:0]                           i_cfg_index,
    input  logic [31:0]                          i_cfg_data
);

    localparam int N_STEPS = (CORDIC_STEPS < rsbb_pkg::ATAN_ENTRIES) ?
                             CORDIC_STEPS : rsbb_pkg::ATAN_ENTRIES;
    localparam int LAT = N_STEPS + 7;

    localparam logic [3:0] REG_HOT_X  = 4'd0;
    localparam logic [3:0] REG_HOT_Y  = 4'd1;
    localparam logic [3:0] REG_WIDTH  = 4'd2;
    localparam logic [3:0] REG_HEIGHT = 4'd3;

    localparam int POS_W  = rsbb_pkg::POS_W;
    localparam int ANG_W  = rsbb_pkg::ANG_W;
    localparam int SCL_W  = rsbb_pkg::SCL_W;
    localparam int OFF_W  = rsbb_pkg::OFF_W;
    localparam int PROD_W = rsbb_pkg::PROD_W;
    localparam int TX_W   = rsbb_pkg::TX_W;
    localparam int XY_W   = rsbb_pkg::XY_W;
    localparam int Z_W    = rsbb_pkg::Z_W;
    localparam int CS_W   = rsbb_pkg::CS_W;
    localparam int RP_W   = rsbb_pkg::RP_W;
    localparam int ROT_W  = rsbb_pkg::ROT_W;
    localparam int EDGE_W = rsbb_pkg::EDGE_W;

    function automatic logic signed [TX_W-1:0] rnd_prod(input logic signed [PROD_W-1:0] p);
        logic signed [PROD_W-1:0] s;
        s = p + 58'sd32768;
        return s[PROD_W-1:16];
    endfunction

    function automatic logic signed [ROT_W-1:0] min2(input logic signed [ROT_W-1:0] a,
                                                     input logic signed [ROT_W-1:0] b);
        return (b < a) ? b : a;
    endfunction

    function automatic logic signed [ROT_W-1:0] max2(input logic signed [ROT_W-1:0] a,
                                                     input logic signed [ROT_W-1:0] b);
        return (b > a) ? b : a;
    endfunction

    function automatic logic signed [POS_W-1:0] sat32(input logic signed [EDGE_W-1:0] v);
        logic signed [POS_W-1:0] r;
        if ((v[EDGE_W-1:POS_W-1] == '0) || (v[EDGE_W-1:POS_W-1] == '1)) begin
            r = v[POS_W-1:0];
        end else if (v[EDGE_W-1]) begin
            r = {1'b1, {(POS_W-1){1'b0}}};
        end else begin
            r = {1'b0, {(POS_W-1){1'b1}}};
        end
        return r;
    endfunction

    // configuration
    logic signed [31:0] r_hot_x;
    logic signed [31:0] r_hot_y;
    logic [15:0]        r_width;
    logic [15:0]        r_height;

    logic accept;
    logic [LAT-1:0] r_vld;

    assign busy        = 1'b0;
    assign o_cfg_ready = 1'b1;
    assign accept      = start && !busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hot_x  <= '0;
            r_hot_y  <= '0;
            r_width  <= '0;
            r_height <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                REG_HOT_X:  r_hot_x  <= $signed(i_cfg_data);
                REG_HOT_Y:  r_hot_y  <= $signed(i_cfg_data);
                REG_WIDTH:  r_width  <= i_cfg_data[15:0];
                REG_HEIGHT: r_height <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[LAT-2:0], accept};
        end
    end

    // input stage: angle clamped to plus or minus pi
    logic signed [ANG_W-1:0] n_ang;
    logic signed [ANG_W-1:0] r_ang;
    logic signed [POS_W-1:0] r_in_px, r_in_py;
    logic signed [SCL_W-1:0] r_sh, r_sv;

    always_comb begin
        if (i_angle > rsbb_pkg::ANGLE_LIMIT) begin
            n_ang = rsbb_pkg::ANGLE_LIMIT;
        end else if (i_angle < rsbb_pkg::ANGLE_LIMIT_N) begin
            n_ang = rsbb_pkg::ANGLE_LIMIT_N;
        end else begin
            n_ang = i_angle;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ang   <= n_ang;
        r_in_px <= i_pos_x;
        r_in_py <= i_pos_y;
        r_sh    <= i_scale_h;
        r_sv    <= i_scale_v;
    end

    // head stage: quadrant fold of the angle, corner offsets times scale
    logic signed [Z_W-1:0]    z_raw, n_z;
    logic                     n_neg;
    logic signed [OFF_W-1:0]  hot_x_ext, hot_y_ext;
    logic signed [OFF_W-1:0]  off_x0, off_x1, off_y0, off_y1;
    logic signed [PROD_W-1:0] p_x0, p_x1, p_y0, p_y1;

    logic signed [PROD_W-1:0] r_p_x0, r_p_x1, r_p_y0, r_p_y1;
    logic signed [Z_W-1:0]    r_hd_z;
    logic                     r_hd_neg;
    logic signed [POS_W-1:0]  r_hd_px, r_hd_py;
    logic                     r_hd_zero;

    assign z_raw = $signed({r_ang[ANG_W-1], r_ang, 14'd0});

    always_comb begin
        n_z   = z_raw;
        n_neg = 1'b0;
        if (z_raw > rsbb_pkg::HALF_PI_Q30) begin
            n_z   = z_raw - rsbb_pkg::PI_Q30;
            n_neg = 1'b1;
        end else if (z_raw < rsbb_pkg::HALF_PI_Q30_N) begin
            n_z   = z_raw + rsbb_pkg::PI_Q30;
            n_neg = 1'b1;
        end
    end

    assign hot_x_ext = $signed({{(OFF_W-32){r_hot_x[31]}}, r_hot_x});
    assign hot_y_ext = $signed({{(OFF_W-32){r_hot_y[31]}}, r_hot_y});
    assign off_x0    = -hot_x_ext;
    assign off_y0    = -hot_y_ext;
    assign off_x1    = $signed({{(OFF_W-32){1'b0}}, r_width, 16'd0}) - hot_x_ext;
    assign off_y1    = $signed({{(OFF_W-32){1'b0}}, r_height, 16'd0}) - hot_y_ext;

    assign p_x0 = off_x0 * r_sh;
    assign p_x1 = off_x1 * r_sh;
    assign p_y0 = off_y0 * r_sv;
    assign p_y1 = off_y1 * r_sv;

    always_ff @(posedge i_clk) begin
        r_p_x0    <= p_x0;
        r_p_x1    <= p_x1;
        r_p_y0    <= p_y0;
        r_p_y1    <= p_y1;
        r_hd_z    <= n_z;
        r_hd_neg  <= n_neg;
        r_hd_px   <= r_in_px;
        r_hd_py   <= r_in_py;
        r_hd_zero <= (r_ang == '0);
    end

    // cordic, one iteration per stage
    rsbb_pkg::t_cstage cin [N_STEPS];
    rsbb_pkg::t_cstage n_c [N_STEPS];
    rsbb_pkg::t_cstage r_c [N_STEPS];

    always_comb begin
        cin[0].x         = rsbb_pkg::CORDIC_GAIN_Q30;
        cin[0].y         = '0;
        cin[0].z         = r_hd_z;
        cin[0].neg       = r_hd_neg;
        cin[0].side.tx0  = rnd_prod(r_p_x0);
        cin[0].side.tx1  = rnd_prod(r_p_x1);
        cin[0].side.ty0  = rnd_prod(r_p_y0);
        cin[0].side.ty1  = rnd_prod(r_p_y1);
        cin[0].side.px   = r_hd_px;
        cin[0].side.py   = r_hd_py;
        cin[0].side.zero = r_hd_zero;
    end

    for (genvar k = 1; k < N_STEPS; k++) begin : g_link
        assign cin[k] = r_c[k-1];
    end

    for (genvar k = 0; k < N_STEPS; k++) begin : g_step
        logic signed [XY_W-1:0] xs, ys;
        logic signed [Z_W-1:0]  at;

        assign xs = $signed(cin[k].x) >>> k;
        assign ys = $signed(cin[k].y) >>> k;
        assign at = $signed({{(Z_W-30){1'b0}}, rsbb_pkg::atan_q30(5'(k))});

        always_comb begin
            n_c[k] = cin[k];
            if (!cin[k].z[Z_W-1]) begin
                n_c[k].x = cin[k].x - ys;
                n_c[k].y = cin[k].y + xs;
                n_c[k].z = cin[k].z - at;
            end else begin
                n_c[k].x = cin[k].x + ys;
                n_c[k].y = cin[k].y - xs;
                n_c[k].z = cin[k].z + at;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_c <= n_c;
    end

    // trig stage: undo the fold, round Q30 to Q16
    logic signed [XY_W-1:0] xf, yf, xr, yr;
    logic signed [CS_W-1:0] r_cos, r_sin;
    rsbb_pkg::t_side        r_tr_side;

    assign xf = r_c[N_STEPS-1].neg ? -r_c[N_STEPS-1].x : r_c[N_STEPS-1].x;
    assign yf = r_c[N_STEPS-1].neg ? -r_c[N_STEPS-1].y : r_c[N_STEPS-1].y;
    assign xr = xf + 33'sd8192;
    assign yr = yf + 33'sd8192;

    always_ff @(posedge i_clk) begin
        r_cos     <= xr[CS_W+13:14];
        r_sin     <= yr[CS_W+13:14];
        r_tr_side <= r_c[N_STEPS-1].side;
    end

    // multiply stage
    logic signed [RP_W-1:0] r_mxc [2];
    logic signed [RP_W-1:0] r_mxs [2];
    logic signed [RP_W-1:0] r_myc [2];
    logic signed [RP_W-1:0] r_mys [2];
    rsbb_pkg::t_side        r_mu_side;

    always_ff @(posedge i_clk) begin
        r_mxc[0]  <= r_tr_side.tx0 * r_cos;
        r_mxs[0]  <= r_tr_side.tx0 * r_sin;
        r_mxc[1]  <= r_tr_side.tx1 * r_cos;
        r_mxs[1]  <= r_tr_side.tx1 * r_sin;
        r_myc[0]  <= r_tr_side.ty0 * r_cos;
        r_mys[0]  <= r_tr_side.ty0 * r_sin;
        r_myc[1]  <= r_tr_side.ty1 * r_cos;
        r_mys[1]  <= r_tr_side.ty1 * r_sin;
        r_mu_side <= r_tr_side;
    end

    // rotate stage: four corners, or plain offsets at zero angle
    logic signed [TX_W-1:0]  txa [2];
    logic signed [TX_W-1:0]  tya [2];
    logic signed [ROT_W-1:0] n_ox [4];
    logic signed [ROT_W-1:0] n_oy [4];
    logic signed [ROT_W-1:0] r_ox [4];
    logic signed [ROT_W-1:0] r_oy [4];
    logic signed [POS_W-1:0] r_rt_px, r_rt_py;

    assign txa[0] = r_mu_side.tx0;
    assign txa[1] = r_mu_side.tx1;
    assign tya[0] = r_mu_side.ty0;
    assign tya[1] = r_mu_side.ty1;

    for (genvar k = 0; k < 4; k++) begin : g_corner
        localparam int A = (k == 1 || k == 2) ? 1 : 0;
        localparam int B = (k >= 2) ? 1 : 0;
        logic signed [RP_W:0] sx, sy;

        assign sx = r_mxc[A] - r_mys[B] + 61'sd32768;
        assign sy = r_mxs[A] + r_myc[B] + 61'sd32768;

        always_comb begin
            if (r_mu_side.zero) begin
                n_ox[k] = $signed({{(ROT_W-TX_W){txa[A][TX_W-1]}}, txa[A]});
                n_oy[k] = $signed({{(ROT_W-TX_W){tya[B][TX_W-1]}}, tya[B]});
            end else begin
                n_ox[k] = sx[RP_W:16];
                n_oy[k] = sy[RP_W:16];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_ox    <= n_ox;
        r_oy    <= n_oy;
        r_rt_px <= r_mu_side.px;
        r_rt_py <= r_mu_side.py;
    end

    // min/max stage, on offsets before the translation
    logic signed [ROT_W-1:0] r_lo_x, r_hi_x, r_lo_y, r_hi_y;
    logic signed [POS_W-1:0] r_mm_px, r_mm_py;

    always_ff @(posedge i_clk) begin
        r_lo_x  <= min2(min2(r_ox[0], r_ox[1]), min2(r_ox[2], r_ox[3]));
        r_hi_x  <= max2(max2(r_ox[0], r_ox[1]), max2(r_ox[2], r_ox[3]));
        r_lo_y  <= min2(min2(r_oy[0], r_oy[1]), min2(r_oy[2], r_oy[3]));
        r_hi_y  <= max2(max2(r_oy[0], r_oy[1]), max2(r_oy[2], r_oy[3]));
        r_mm_px <= r_rt_px;
        r_mm_py <= r_rt_py;
    end

    // output stage: translate and saturate
    logic signed [EDGE_W-1:0] px_ext, py_ext;
    logic signed [EDGE_W-1:0] e_left, e_top, e_right, e_bottom;
    logic signed [POS_W-1:0]  r_box_left, r_box_top, r_box_right, r_box_bottom;

    assign px_ext   = $signed({{(EDGE_W-POS_W){r_mm_px[POS_W-1]}}, r_mm_px});
    assign py_ext   = $signed({{(EDGE_W-POS_W){r_mm_py[POS_W-1]}}, r_mm_py});
    assign e_left   = $signed({{(EDGE_W-ROT_W){r_lo_x[ROT_W-1]}}, r_lo_x}) + px_ext;
    assign e_right  = $signed({{(EDGE_W-ROT_W){r_hi_x[ROT_W-1]}}, r_hi_x}) + px_ext;
    assign e_top    = $signed({{(EDGE_W-ROT_W){r_lo_y[ROT_W-1]}}, r_lo_y}) + py_ext;
    assign e_bottom = $signed({{(EDGE_W-ROT_W){r_hi_y[ROT_W-1]}}, r_hi_y}) + py_ext;

    always_ff @(posedge i_clk) begin
        r_box_left   <= sat32(e_left);
        r_box_top    <= sat32(e_top);
        r_box_right  <= sat32(e_right);
        r_box_bottom <= sat32(e_bottom);
    end

    assign o_done       = r_vld[LAT-1];
    assign o_box_left   = r_box_left;
    assign o_box_top    = r_box_top;
    assign o_box_right  = r_box_right;
    assign o_box_bottom = r_box_bottom;

endmodule

>>> tb/rsbb_box_checker.sv
// register codes, the expected-box prediction and the result checker of the bounding box unit
`timescale 1ns / 100ps

package rsbb_tb_pkg;

    typedef enum logic [3:0] {
        REG_HOT_X  = 4'd0,
        REG_HOT_Y  = 4'd1,
        REG_WIDTH  = 4'd2,
        REG_HEIGHT = 4'd3
    } t_cfg_reg;

    // first index with no register behind it
    localparam logic [3:0] REG_UNUSED_LO = 4'd4;

    typedef struct packed {
        logic signed [31:0] left;
        logic signed [31:0] top;
        logic signed [31:0] right;
        logic signed [31:0] bottom;
    } t_box;

endpackage

module rsbb_box_checker #(
    parameter int CORDIC_STEPS = 16
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_start,
    input  logic                                 i_busy,
    input  logic signed [rsbb_pkg::POS_W-1:0]    i_pos_x,
    input  logic signed [rsbb_pkg::POS_W-1:0]    i_pos_y,
    input  logic signed [rsbb_pkg::ANG_W-1:0]    i_angle,
    input  logic signed [rsbb_pkg::SCL_W-1:0]    i_scale_h,
    input  logic signed [rsbb_pkg::SCL_W-1:0]    i_scale_v,
    input  logic                                 i_done,
    input  logic signed [rsbb_pkg::POS_W-1:0]    i_box_left,
    input  logic signed [rsbb_pkg::POS_W-1:0]    i_box_top,
    input  logic signed [rsbb_pkg::POS_W-1:0]    i_box_right,
    input  logic signed [rsbb_pkg::POS_W-1:0]    i_box_bottom,
    input  logic                                 i_cfg_valid,
    input  logic                                 i_cfg_ready,
    input  logic [3:0]                           i_cfg_index,
    input  logic [31:0]                          i_cfg_data,
    output int                                   o_pending,
    output int                                   o_fail_count
);

    localparam longint ANGLE_MAX   = 64'sd205887;
    localparam longint HALF_PI_FIX = 64'sd1686629713;
    localparam longint PI_FIX      = 64'sd3373259426;
    localparam longint GAIN_FIX    = 64'sd652032874;
    localparam longint S32_MAX     = 64'sd2147483647;
    localparam longint S32_MIN     = -64'sd2147483648;
    localparam int     ATAN_COUNT  = 24;

    // atan(2^-i) in Q30, truncated
    longint atan_fix [ATAN_COUNT] = '{
        843314856, 497837829, 263043836, 133525158, 67021686, 33543515,
        16775850, 8388437, 4194282, 2097149, 1048575, 524287,
        262143, 131071, 65535, 32767, 16383, 8191,
        4095, 2047, 1023, 511, 255, 127
    };

    logic signed [31:0]   hot_x;
    logic signed [31:0]   hot_y;
    logic [15:0]          spr_w;
    logic [15:0]          spr_h;
    rsbb_tb_pkg::t_box    expected_boxes [$];
    int                   waiting    = 0;
    int                   fail_total = 0;

    assign o_pending    = waiting;
    assign o_fail_count = fail_total;

    // round half up, then floor shift
    function automatic longint round_q(input longint v, input int s);
        return (v + (longint'(1) << (s - 1))) >>> s;
    endfunction

    function automatic logic signed [31:0] clamp32(input longint v);
        if (v > S32_MAX) return 32'sh7FFF_FFFF;
        if (v < S32_MIN) return 32'sh8000_0000;
        return v[31:0];
    endfunction

    function automatic rsbb_tb_pkg::t_box predict_box(input logic signed [31:0] px, py,
                                                      input logic signed [18:0] ang_in,
                                                      input logic signed [23:0] sh, sv);
        longint ang, z, rx, ry, xsh, ysh, cos_q, sin_q, cx_q, cy_q;
        longint off_x [2];
        longint off_y [2];
        longint corner_x [4];
        longint corner_y [4];
        longint lo_x, hi_x, lo_y, hi_y;
        bit     flip;
        int     i, k;
        rsbb_tb_pkg::t_box b;

        ang = ang_in;
        if (ang > ANGLE_MAX) ang = ANGLE_MAX;
        if (ang < -ANGLE_MAX) ang = -ANGLE_MAX;

        off_x[0] = round_q(-longint'(hot_x) * longint'(sh), 16);
        off_y[0] = round_q(-longint'(hot_y) * longint'(sv), 16);
        off_x[1] = round_q((longint'(spr_w) * 65536 - longint'(hot_x)) * longint'(sh), 16);
        off_y[1] = round_q((longint'(spr_h) * 65536 - longint'(hot_y)) * longint'(sv), 16);

        cos_q = 0;
        sin_q = 0;
        if (ang != 0) begin
            z    = ang * 16384;
            rx   = GAIN_FIX;
            ry   = 0;
            flip = 1'b0;
            // fold into the right half plane, negate the vector afterwards
            if (z > HALF_PI_FIX) begin
                z    = z - PI_FIX;
                flip = 1'b1;
            end else if (z < -HALF_PI_FIX) begin
                z    = z + PI_FIX;
                flip = 1'b1;
            end
            for (i = 0; i < CORDIC_STEPS && i < ATAN_COUNT; i++) begin
                xsh = rx >>> i;
                ysh = ry >>> i;
                if (z >= 0) begin
                    rx = rx - ysh;
                    ry = ry + xsh;
                    z  = z - atan_fix[i];
                end else begin
                    rx = rx + ysh;
                    ry = ry - xsh;
                    z  = z + atan_fix[i];
                end
            end
            if (flip) begin
                rx = -rx;
                ry = -ry;
            end
            cos_q = round_q(rx, 14);
            sin_q = round_q(ry, 14);
        end

        for (k = 0; k < 4; k++) begin
            cx_q = off_x[(k == 1 || k == 2) ? 1 : 0];
            cy_q = off_y[(k >= 2) ? 1 : 0];
            if (ang != 0) begin
                corner_x[k] = round_q(cx_q * cos_q - cy_q * sin_q, 16) + longint'(px);
                corner_y[k] = round_q(cx_q * sin_q + cy_q * cos_q, 16) + longint'(py);
            end else begin
                corner_x[k] = cx_q + longint'(px);
                corner_y[k] = cy_q + longint'(py);
            end
        end

        lo_x = corner_x[0];
        hi_x = corner_x[0];
        lo_y = corner_y[0];
        hi_y = corner_y[0];
        for (k = 1; k < 4; k++) begin
            if (corner_x[k] < lo_x) lo_x = corner_x[k];
            if (corner_x[k] > hi_x) hi_x = corner_x[k];
            if (corner_y[k] < lo_y) lo_y = corner_y[k];
            if (corner_y[k] > hi_y) hi_y = corner_y[k];
        end

        b.left   = clamp32(lo_x);
        b.top    = clamp32(lo_y);
        b.right  = clamp32(hi_x);
        b.bottom = clamp32(hi_y);
        return b;
    endfunction

    function automatic int edge_mismatch(input string field,
                                         input logic signed [31:0] want, got);
        if (got === want) return 0;
        $error("%s mismatch: expected %0d, got %0d", field, want, got);
        return 1;
    endfunction

    always @(posedge i_clk) begin
        rsbb_tb_pkg::t_box want;
        int                errs;
        errs = 0;
        if (!i_rst_n) begin
            hot_x <= '0;
            hot_y <= '0;
            spr_w <= '0;
            spr_h <= '0;
            expected_boxes.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                unique case (i_cfg_index)
                    rsbb_tb_pkg::REG_HOT_X:  hot_x <= i_cfg_data;
                    rsbb_tb_pkg::REG_HOT_Y:  hot_y <= i_cfg_data;
                    rsbb_tb_pkg::REG_WIDTH:  spr_w <= i_cfg_data[15:0];
                    rsbb_tb_pkg::REG_HEIGHT: spr_h <= i_cfg_data[15:0];
                    default: ;
                endcase
            end
            // retire the oldest box before queuing one taken at this edge
            if (i_done) begin
                if (expected_boxes.size() == 0) begin
                    $error("box with no placement pending: %0d %0d %0d %0d",
                           i_box_left, i_box_top, i_box_right, i_box_bottom);
                    errs = 1;
                end else begin
                    want = expected_boxes.pop_front();
                    errs = edge_mismatch("box_left", want.left, i_box_left)
                         + edge_mismatch("box_top", want.top, i_box_top)
                         + edge_mismatch("box_right", want.right, i_box_right)
                         + edge_mismatch("box_bottom", want.bottom, i_box_bottom);
                end
            end
            if (i_start && !i_busy)
                expected_boxes.push_back(predict_box(i_pos_x, i_pos_y, i_angle,
                                                     i_scale_h, i_scale_v));
        end
        fail_total <= fail_total + errs;
        waiting    <= expected_boxes.size();
    end

endmodule

>>> tb/tb_top.sv
// stimulus, configuration phases and verdict for the rotated sprite bounding box unit
`timescale 1ns / 100ps

module tb_top;

    localparam int STEPS            = 16;
    localparam int LATENCY_PAD      = STEPS + 6 + 16;
    localparam int CYCLE_LIMIT      = 400000;
    localparam int SETTING_COUNT    = 6;
    localparam int ITEMS_PER_CHUNK  = 67;
    localparam logic signed [23:0] SCALE_ONE = 24'sd65536;

    logic                                 i_clk       = 1'b0;
    logic                                 i_rst_n     = 1'b0;
    logic                                 start       = 1'b0;
    logic                                 busy;
    logic signed [rsbb_pkg::POS_W-1:0]    i_pos_x     = '0;
    logic signed [rsbb_pkg::POS_W-1:0]    i_pos_y     = '0;
    logic signed [rsbb_pkg::ANG_W-1:0]    i_angle     = '0;
    logic signed [rsbb_pkg::SCL_W-1:0]    i_scale_h   = '0;
    logic signed [rsbb_pkg::SCL_W-1:0]    i_scale_v   = '0;
    logic                                 o_done;
    logic signed [rsbb_pkg::POS_W-1:0]    o_box_left;
    logic signed [rsbb_pkg::POS_W-1:0]    o_box_top;
    logic signed [rsbb_pkg::POS_W-1:0]    o_box_right;
    logic signed [rsbb_pkg::POS_W-1:0]    o_box_bottom;
    logic                                 i_cfg_valid = 1'b0;
    logic                                 o_cfg_ready;
    logic [3:0]                           i_cfg_index = '0;
    logic [31:0]                          i_cfg_data  = '0;
    int                                   pending;
    int                                   fail_count;
    int                                   cycle_count = 0;

    always #5 i_clk = ~i_clk;

    rotated_sprite_bounding_box #(
        .CORDIC_STEPS(STEPS)
    ) DUT (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .start(start),
        .busy(busy),
        .i_pos_x(i_pos_x),
        .i_pos_y(i_pos_y),
        .i_angle(i_angle),
        .i_scale_h(i_scale_h),
        .i_scale_v(i_scale_v),
        .o_done(o_done),
        .o_box_left(o_box_left),
        .o_box_top(o_box_top),
        .o_box_right(o_box_right),
        .o_box_bottom(o_box_bottom),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data(i_cfg_data)
    );

    rsbb_box_checker #(
        .CORDIC_STEPS(STEPS)
    ) u_box_check (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_start(start),
        .i_busy(busy),
        .i_pos_x(i_pos_x),
        .i_pos_y(i_pos_y),
        .i_angle(i_angle),
        .i_scale_h(i_scale_h),
        .i_scale_v(i_scale_v),
        .i_done(o_done),
        .i_box_left(o_box_left),
        .i_box_top(o_box_top),
        .i_box_right(o_box_right),
        .i_box_bottom(o_box_bottom),
        .i_cfg_valid(i_cfg_valid),
        .i_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data(i_cfg_data),
        .o_pending(pending),
        .o_fail_count(fail_count)
    );

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // holds the placement until the edge that takes it
    task automatic send_placement(input logic signed [31:0] px, py,
                                  input logic signed [18:0] ang,
                                  input logic signed [23:0] sh, sv);
        start     <= 1'b1;
        i_pos_x   <= px;
        i_pos_y   <= py;
        i_angle   <= ang;
        i_scale_h <= sh;
        i_scale_v <= sv;
        do @(posedge i_clk); while (busy);
    endtask

    task automatic drain();
        start <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
    endtask

    task automatic write_reg(input logic [3:0] idx, input logic [31:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
    endtask

    task automatic configure(input logic [31:0] hx, hy, input logic [15:0] w, h);
        write_reg(rsbb_tb_pkg::REG_HOT_X, hx);
        write_reg(rsbb_tb_pkg::REG_HOT_Y, hy);
        write_reg(rsbb_tb_pkg::REG_WIDTH, {16'($urandom), w});
        write_reg(rsbb_tb_pkg::REG_HEIGHT, {16'($urandom), h});
        // an index past the register file must leave the settings alone
        write_reg(4'($urandom_range(15, rsbb_tb_pkg::REG_UNUSED_LO)), $urandom);
        i_cfg_valid <= 1'b0;
    endtask

    initial begin
        logic signed [31:0] px, py, hx, hy;
        logic signed [18:0] ang;
        logic signed [23:0] sh, sv;
        logic [15:0]        w, h;
        int                 idle_pct, pick, s, chunk, n;

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // 8.5 x 4.25 pivot on a 16 x 12 sprite
        configure(32'sd557056, 32'sd278528, 16'd16, 16'd12);

        send_placement(32'sd0, 32'sd0, 19'sd0, SCALE_ONE, SCALE_ONE);
        send_placement(32'sd6553600, -32'sd3276800, 19'sd0, -SCALE_ONE, -SCALE_ONE);
        send_placement(32'sd6553600, 32'sd6553600, 19'sd205887, SCALE_ONE, SCALE_ONE);
        send_placement(32'sd6553600, 32'sd6553600, -19'sd205887, SCALE_ONE, SCALE_ONE);
        // angle codes past plus or minus pi clamp to plus or minus pi
        send_placement(32'sd6553600, 32'sd6553600, 19'sh3FFFF, SCALE_ONE, SCALE_ONE);
        send_placement(32'sd6553600, 32'sd6553600, 19'sh40000, SCALE_ONE, SCALE_ONE);
        // both sides of the quarter turn fold
        send_placement(32'sd0, 32'sd0, 19'sd102943, SCALE_ONE, SCALE_ONE);
        send_placement(32'sd0, 32'sd0, 19'sd102944, SCALE_ONE, SCALE_ONE);
        send_placement(32'sd0, 32'sd0, -19'sd102944, SCALE_ONE, SCALE_ONE);
        send_placement(32'sd0, 32'sd0, -19'sd102943, SCALE_ONE, SCALE_ONE);
        send_placement(32'sd65536, 32'sd65536, 19'sd1, SCALE_ONE, SCALE_ONE);
        send_placement(32'sd65536, 32'sd65536, -19'sd1, SCALE_ONE, SCALE_ONE);
        send_placement(32'sd0, 32'sd0, 19'sd0, 24'sh7FFFFF, 24'sh7FFFFF);
        send_placement(32'sd0, 32'sd0, 19'sd51472, 24'sh800000, 24'sh800000);
        send_placement(32'sd327680, 32'sd327680, 19'sd12345, 24'sd0, 24'sd0);
        // edges pushed past the 32-bit range
        send_placement(32'sh7FFFFFFF, 32'sh7FFFFFFF, 19'sd0, SCALE_ONE, SCALE_ONE);
        send_placement(32'sh80000000, 32'sh80000000, 19'sd0, SCALE_ONE, SCALE_ONE);
        send_placement(32'sh7FFFFFFF, 32'sh80000000, 19'sd30000, 24'sh7FFFFF, 24'sh7FFFFF);
        send_placement(32'sh80000000, 32'sh7FFFFFFF, -19'sd30000, 24'sh800000, 24'sh800000);
        send_placement(32'sd6553600, 32'sd3276800, 19'sd25736, SCALE_ONE, -24'sd163840);
        drain();

        for (s = 0; s < SETTING_COUNT; s++) begin
            unique case (s)
                1: begin
                    hx = 32'sh80000000;
                    hy = 32'sh7FFFFFFF;
                    w  = 16'hFFFF;
                    h  = 16'hFFFF;
                end
                2: begin
                    hx = '0;
                    hy = '0;
                    w  = '0;
                    h  = '0;
                end
                3: begin
                    hx = 32'sh7FFFFFFF;
                    hy = 32'sh80000000;
                    w  = '0;
                    h  = 16'hFFFF;
                end
                4: begin
                    hx = $urandom;
                    hy = $urandom;
                    w  = 16'($urandom);
                    h  = 16'($urandom);
                end
                default: begin
                    w  = 16'($urandom_range(1, 64));
                    h  = 16'($urandom_range(1, 64));
                    // pivot anywhere from one sprite left of the origin to its far edge
                    hx = int'($urandom_range(0, 2 * 65536 * w)) - 65536 * int'(w);
                    hy = int'($urandom_range(0, 2 * 65536 * h)) - 65536 * int'(h);
                end
            endcase
            drain();
            configure(hx, hy, w, h);

            for (chunk = 0; chunk < 3; chunk++) begin
                idle_pct = (chunk == 0) ? 0 : (chunk == 1) ? 86 : 6;
                for (n = 0; n < ITEMS_PER_CHUNK; n++) begin
                    px = $urandom;
                    py = $urandom;
                    if ($urandom_range(99) < 70) begin
                        px = px >>> 6;
                        py = py >>> 6;
                    end
                    pick = $urandom_range(99);
                    if (pick < 10)
                        ang = '0;
                    else if (pick < 20)
                        ang = 19'($urandom);
                    else
                        ang = 19'(int'($urandom_range(0, 411774)) - 205887);
                    if ($urandom_range(99) < 70) begin
                        sh = 24'(int'($urandom_range(0, 524288)) - 262144);
                        sv = 24'(int'($urandom_range(0, 524288)) - 262144);
                    end else begin
                        sh = 24'($urandom);
                        sv = 24'($urandom);
                    end
                    send_placement(px, py, ang, sh, sv);
                    while ($urandom_range(99) < idle_pct) begin
                        start <= 1'b0;
                        @(posedge i_clk);
                    end
                end
            end
        end

        drain();
        repeat (LATENCY_PAD) @(posedge i_clk);
        if (fail_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
